// ===== hdl/falru_pkg.sv =====
// Package: shared widths, controller states and controller/datapath command types.
`default_nettype none
package falru_pkg;
    localparam int NUM_WAYS_DEF     = 8;
    localparam int BLOCK_WORDS_DEF  = 16;
    localparam int MEMORY_WORDS_DEF = 4096;

    localparam int ADDR_W = 12;
    localparam int DATA_W = 32;
    localparam int WAY_W  = 3;
    localparam int VBLK_W = 8;
    localparam int CNT_W  = 32;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WB,
        ST_FILL,
        ST_ACCESS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic wb_rd;
        logic fill_rd;
        logic clr;
        logic acc;
        logic done;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic wb;
    } t_dp_sts;
endpackage
`default_nettype wire

// ===== hdl/falru_req_if.sv =====
// Request channel interface: one load or store beat.
`default_nettype none
interface falru_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [11:0] word_address;
    logic [31:0] write_data;

    modport source (output valid, command, word_address, write_data, input ready);
    modport sink   (input valid, command, word_address, write_data, output ready);
endinterface
`default_nettype wire

// ===== hdl/falru_rsp_if.sv =====
// Response channel interface: one result beat with counters.
`default_nettype none
interface falru_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        hit;
    logic        wrote_back;
    logic [2:0]  way_used;
    logic [7:0]  victim_block;
    logic [31:0] read_count;
    logic [31:0] read_miss_count;
    logic [31:0] write_count;
    logic [31:0] write_miss_count;

    modport source (output valid, read_data, hit, wrote_back, way_used, victim_block,
                    read_count, read_miss_count, write_count, write_miss_count,
                    input ready);
    modport sink   (input valid, read_data, hit, wrote_back, way_used, victim_block,
                    read_count, read_miss_count, write_count, write_miss_count,
                    output ready);
endinterface
`default_nettype wire

// ===== hdl/falru_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module falru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    output      logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= mem[i_addr];
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/falru_ctrl.sv =====
// Controller: sequences clear, lookup, write-back, fill, access and result.
`default_nettype none
module falru_ctrl #(
    parameter int BLOCK_WORDS  = 16,
    parameter int MEMORY_WORDS = 4096,
    localparam int SW  = $clog2(BLOCK_WORDS + 1),
    localparam int MAW = $clog2(MEMORY_WORDS)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire falru_pkg::t_dp_sts i_sts,
    output      falru_pkg::t_dp_cmd o_cmd,
    output      logic [SW-1:0]      o_step,
    output      logic [MAW-1:0]     o_clr_addr
);
    import falru_pkg::*;

    t_state         r_state, n_state;
    logic [SW-1:0]  r_step, n_step;
    logic [MAW-1:0] r_clr, n_clr;
    logic           r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_step      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_clr     = r_clr + 1'b1;
                if (r_clr == MAW'(MEMORY_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_step       = '0;
                if (i_sts.hit) begin
                    n_state = ST_ACCESS;
                end else if (i_sts.wb) begin
                    n_state = ST_WB;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_WB: begin
                // one extra step drains the last pending write
                o_cmd.wb_rd = (r_step != SW'(BLOCK_WORDS));
                if (r_step == SW'(BLOCK_WORDS)) begin
                    n_step  = '0;
                    n_state = ST_FILL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_FILL: begin
                o_cmd.fill_rd = (r_step != SW'(BLOCK_WORDS));
                if (r_step == SW'(BLOCK_WORDS)) begin
                    n_step  = '0;
                    n_state = ST_ACCESS;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_ACCESS: begin
                o_cmd.acc = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.done  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_step      = r_step;
    assign o_clr_addr  = r_clr;
endmodule
`default_nettype wire

// ===== hdl/falru_dp.sv =====
// Datapath: tags, ages, line RAM, backing RAM, counters and result register.
`default_nettype none
module falru_dp #(
    parameter int NUM_WAYS     = 8,
    parameter int BLOCK_WORDS  = 16,
    parameter int MEMORY_WORDS = 4096,
    localparam int SW  = $clog2(BLOCK_WORDS + 1),
    localparam int MAW = $clog2(MEMORY_WORDS)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire falru_pkg::t_dp_cmd           i_cmd,
    input  wire logic [SW-1:0]                i_step,
    input  wire logic [MAW-1:0]               i_clr_addr,
    output      falru_pkg::t_dp_sts           o_sts,
    input  wire logic                         i_command,
    input  wire logic [falru_pkg::ADDR_W-1:0] i_word_address,
    input  wire logic [falru_pkg::DATA_W-1:0] i_write_data,
    output      logic [falru_pkg::DATA_W-1:0] o_read_data,
    output      logic                         o_hit,
    output      logic                         o_wrote_back,
    output      logic [falru_pkg::WAY_W-1:0]  o_way_used,
    output      logic [falru_pkg::VBLK_W-1:0] o_victim_block,
    output      logic [falru_pkg::CNT_W-1:0]  o_read_count,
    output      logic [falru_pkg::CNT_W-1:0]  o_read_miss_count,
    output      logic [falru_pkg::CNT_W-1:0]  o_write_count,
    output      logic [falru_pkg::CNT_W-1:0]  o_write_miss_count
);
    import falru_pkg::*;

    localparam int LOG_BW = $clog2(BLOCK_WORDS);
    localparam int TAGW   = ADDR_W - LOG_BW;
    localparam int WAYW   = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
    localparam int AGW    = $clog2(NUM_WAYS + 1);
    localparam int LDEPTH = NUM_WAYS * BLOCK_WORDS;
    localparam int CAW    = LDEPTH > 1 ? $clog2(LDEPTH) : 1;
    localparam logic [ADDR_W-1:0] AMASK =
        MEMORY_WORDS >= (1 << ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'(MEMORY_WORDS - 1);
    localparam logic [ADDR_W-1:0] OMASK = ADDR_W'(BLOCK_WORDS - 1);

    logic              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_wdata;
    logic [TAGW-1:0]   r_tag     [NUM_WAYS];
    logic [AGW-1:0]    r_age     [NUM_WAYS];
    logic              r_valid   [NUM_WAYS];
    logic              r_dirty   [NUM_WAYS];
    logic              r_hit, r_wb;
    logic [WAYW-1:0]   r_way;
    logic [TAGW-1:0]   r_vtag;
    logic              r_pend_wb, r_pend_fill;
    logic [SW-1:0]     r_pend_off;
    logic [CNT_W-1:0]  r_cnt_rd, r_cnt_rdm, r_cnt_wr, r_cnt_wrm;

    logic [TAGW-1:0]   blk;
    logic [ADDR_W-1:0] off;
    logic              hit_c, wb_c, found_free;
    logic [WAYW-1:0]   hit_way, vic_way, way_c;
    logic [AGW-1:0]    best_age;

    assign blk = TAGW'(r_addr >> LOG_BW);
    assign off = r_addr & OMASK;

    function automatic logic [CAW-1:0] cidx(logic [WAYW-1:0] w, logic [ADDR_W-1:0] o);
        return CAW'(w) * CAW'(BLOCK_WORDS) + CAW'(o);
    endfunction

    function automatic logic [MAW-1:0] midx(logic [TAGW-1:0] t, logic [ADDR_W-1:0] o);
        logic [ADDR_W-1:0] full;
        full = ADDR_W'(t) * ADDR_W'(BLOCK_WORDS) + o;
        return MAW'(full);
    endfunction

    // tag match and victim pick
    always_comb begin
        hit_c      = 1'b0;
        hit_way    = '0;
        vic_way    = '0;
        found_free = 1'b0;
        best_age   = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (r_valid[i] && r_tag[i] == blk) begin
                hit_c   = 1'b1;
                hit_way = WAYW'(i);
            end
            if (!found_free) begin
                if (r_age[i] == '0) begin
                    found_free = 1'b1;
                    vic_way    = WAYW'(i);
                end else if (r_age[i] > best_age) begin
                    best_age = r_age[i];
                    vic_way  = WAYW'(i);
                end
            end
        end
        way_c = hit_c ? hit_way : vic_way;
        wb_c  = !hit_c && r_valid[vic_way] && r_dirty[vic_way];
    end

    assign o_sts.hit = hit_c;
    assign o_sts.wb  = wb_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_wb   <= 1'b0;
            r_pend_fill <= 1'b0;
            r_cnt_rd    <= '0;
            r_cnt_rdm   <= '0;
            r_cnt_wr    <= '0;
            r_cnt_wrm   <= '0;
            for (int i = 0; i < NUM_WAYS; i++) begin
                r_valid[i] <= 1'b0;
                r_dirty[i] <= 1'b0;
                r_age[i]   <= '0;
            end
        end else begin
            r_pend_wb   <= i_cmd.wb_rd;
            r_pend_fill <= i_cmd.fill_rd;
            if (i_cmd.lookup) begin
                for (int i = 0; i < NUM_WAYS; i++) begin
                    if (WAYW'(i) != way_c && r_age[i] != '0 &&
                        (!hit_c || r_age[i] < r_age[way_c])) begin
                        r_age[i] <= r_age[i] + 1'b1;
                    end
                end
                r_age[way_c]   <= AGW'(1);
                r_valid[way_c] <= 1'b1;
                if (!hit_c) begin
                    r_dirty[way_c] <= 1'b0;
                end
            end
            if (i_cmd.acc && r_cmd == CMD_STORE) begin
                r_dirty[r_way] <= 1'b1;
            end
            if (i_cmd.done) begin
                if (r_cmd == CMD_STORE) begin
                    r_cnt_wr <= r_cnt_wr + 1'b1;
                    if (!r_hit) r_cnt_wrm <= r_cnt_wrm + 1'b1;
                end else begin
                    r_cnt_rd <= r_cnt_rd + 1'b1;
                    if (!r_hit) r_cnt_rdm <= r_cnt_rdm + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_off <= i_step;
        if (i_cmd.accept) begin
            r_cmd   <= i_command;
            r_addr  <= i_word_address & AMASK;
            r_wdata <= i_write_data;
        end
        if (i_cmd.lookup) begin
            r_hit        <= hit_c;
            r_wb         <= wb_c;
            r_way        <= way_c;
            r_vtag       <= r_tag[way_c];
            r_tag[way_c] <= blk;
        end
    end

    // RAM port steering
    logic              l_en, l_we, b_en, b_we;
    logic [CAW-1:0]    l_addr;
    logic [MAW-1:0]    b_addr;
    logic [DATA_W-1:0] l_wdata, b_wdata, l_rdata, b_rdata;

    always_comb begin
        l_en    = 1'b0;
        l_we    = 1'b0;
        l_addr  = cidx(r_way, off);
        l_wdata = r_wdata;
        b_en    = 1'b0;
        b_we    = 1'b0;
        b_addr  = i_clr_addr;
        b_wdata = '0;
        if (i_cmd.clr) begin
            b_en = 1'b1;
            b_we = 1'b1;
        end else if (r_pend_wb) begin
            b_en    = 1'b1;
            b_we    = 1'b1;
            b_addr  = midx(r_vtag, ADDR_W'(r_pend_off));
            b_wdata = l_rdata;
        end else if (i_cmd.fill_rd) begin
            b_en   = 1'b1;
            b_addr = midx(blk, ADDR_W'(i_step));
        end
        if (i_cmd.wb_rd) begin
            l_en   = 1'b1;
            l_addr = cidx(r_way, ADDR_W'(i_step));
        end else if (r_pend_fill) begin
            l_en    = 1'b1;
            l_we    = 1'b1;
            l_addr  = cidx(r_way, ADDR_W'(r_pend_off));
            l_wdata = b_rdata;
        end else if (i_cmd.acc) begin
            l_en = 1'b1;
            l_we = (r_cmd == CMD_STORE);
        end
    end

    falru_ram #(.WIDTH(DATA_W), .DEPTH(LDEPTH)) u_line_ram (
        .i_clk  (i_clk),
        .i_en   (l_en),
        .i_we   (l_we),
        .i_addr (l_addr),
        .i_wdata(l_wdata),
        .o_rdata(l_rdata)
    );

    falru_ram #(.WIDTH(DATA_W), .DEPTH(MEMORY_WORDS)) u_back_ram (
        .i_clk  (i_clk),
        .i_en   (b_en),
        .i_we   (b_we),
        .i_addr (b_addr),
        .i_wdata(b_wdata),
        .o_rdata(b_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            o_read_data    <= (r_cmd == CMD_STORE) ? '0 : l_rdata;
            o_hit          <= r_hit;
            o_wrote_back   <= r_wb;
            o_way_used     <= WAY_W'(r_way);
            o_victim_block <= r_wb ? VBLK_W'(r_vtag) : '0;
        end
    end

    assign o_read_count       = r_cnt_rd;
    assign o_read_miss_count  = r_cnt_rdm;
    assign o_write_count      = r_cnt_wr;
    assign o_write_miss_count = r_cnt_wrm;
endmodule
`default_nettype wire

// ===== hdl/fully_associative_lru_cache.sv =====
// Top level: fully associative write-back LRU cache with internal backing memory.
//
//  channel  dir  beat
//  i_req    in   command, word_address, write_data
//  o_rsp    out  read_data, hit, wrote_back, way_used, victim_block, four counters
//
//  One request at a time. Hit: lookup, access, then the result beat.
//  Miss: after lookup, a dirty victim line is first written back word by word,
//  then the new line is filled word by word before the access; the word-by-word
//  transfer is set by the single port of the line RAM and of the backing RAM.
//  After reset the backing memory is cleared word by word, with ready low.
//  A result waits in the output register; the next request is taken meanwhile.
`default_nettype none
module fully_associative_lru_cache #(
    parameter int NUM_WAYS     = falru_pkg::NUM_WAYS_DEF,
    parameter int BLOCK_WORDS  = falru_pkg::BLOCK_WORDS_DEF,
    parameter int MEMORY_WORDS = falru_pkg::MEMORY_WORDS_DEF
) (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    falru_req_if.sink    i_req,
    falru_rsp_if.source  o_rsp
);
    import falru_pkg::*;

    localparam int SW  = $clog2(BLOCK_WORDS + 1);
    localparam int MAW = $clog2(MEMORY_WORDS);

    t_dp_cmd        cmd;
    t_dp_sts        sts;
    logic [SW-1:0]  step;
    logic [MAW-1:0] clr_addr;

    falru_ctrl #(.BLOCK_WORDS(BLOCK_WORDS), .MEMORY_WORDS(MEMORY_WORDS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_step     (step),
        .o_clr_addr (clr_addr)
    );

    falru_dp #(
        .NUM_WAYS(NUM_WAYS), .BLOCK_WORDS(BLOCK_WORDS), .MEMORY_WORDS(MEMORY_WORDS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_step            (step),
        .i_clr_addr        (clr_addr),
        .o_sts             (sts),
        .i_command         (i_req.command),
        .i_word_address    (i_req.word_address),
        .i_write_data      (i_req.write_data),
        .o_read_data       (o_rsp.read_data),
        .o_hit             (o_rsp.hit),
        .o_wrote_back      (o_rsp.wrote_back),
        .o_way_used        (o_rsp.way_used),
        .o_victim_block    (o_rsp.victim_block),
        .o_read_count      (o_rsp.read_count),
        .o_read_miss_count (o_rsp.read_miss_count),
        .o_write_count     (o_rsp.write_count),
        .o_write_miss_count(o_rsp.write_miss_count)
    );

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr |-> !i_req.ready) else $error("request taken during memory clear");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready) else $error("second request in flight");

    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.hit) |-> !o_rsp.wrote_back) else $error("hit with write-back");

    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.wrote_back) |-> (o_rsp.victim_block == '0))
        else $error("victim block set without write-back");
endmodule
`default_nettype wire
